// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("fail");
// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("fail");
`endif

// ===== rtl/q4d_pkg.sv =====
// Package: constants and the half-scale times nibble function.
package q4d_pkg;
  localparam int unsigned BlockBytes = 18;
  localparam int unsigned BlockElems = 32;

  typedef struct packed {
    logic [31:0] index;
    logic [31:0] value;
    logic        last;
  } res_t;

  function automatic logic [31:0] scaled_bits(input logic [3:0] nib, input logic [15:0] half);
    logic       hs;
    logic [4:0] he;
    logic [10:0] m;
    logic       wneg;
    logic [3:0] wmag;
    logic       sgn;
    logic [14:0] p;
    logic [3:0] k;
    logic [7:0] bexp;
    logic [31:0] r;
    logic [22:0] frac;
    logic [7:0] ebias;
    hs = half[15];
    he = half[14:10];
    wneg = (nib < 4'd8);
    wmag = wneg ? (4'd8 - nib) : (nib - 4'd8);
    sgn = wneg ^ hs;
    m = (he == 5'd0) ? {1'b0, half[9:0]} : {1'b1, half[9:0]};
    // biased exponent for p bit 0: e + 127
    ebias = (he == 5'd0) ? 8'd103 : (8'd102 + {3'b0, he});
    p = {4'b0, m} * {11'b0, wmag};
    k = 4'd0;
    for (int i = 1; i < 14; i++) begin
      if (p[i]) k = 4'(i);
    end
    bexp = ebias + {4'b0, k};
    // leading one of p drops out, the rest lands left-aligned in the fraction
    frac = 23'({p, 9'b0} << (5'd14 - {1'b0, k}));
    if (he == 5'h1F) begin
      r = (wmag == 4'd0) ? 32'h7FC00000 : {sgn, 31'h7F800000};
    end else if (p == 15'd0) begin
      r = {sgn, 31'd0};
    end else begin
      r = {sgn, bexp, frac};
    end
    return r;
  endfunction
endpackage

// ===== rtl/q4d_parser.sv =====
// Block parser: tracks byte position, scale and block number.
module q4d_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  data_byte_i,
  input  logic        tensor_start_i,
  output logic        weight_o,
  output logic [3:0]  lane_o,
  output logic [26:0] block_o,
  output logic [15:0] scale_o
);
  logic [4:0]  pos_q, pos_d, pos;
  logic [7:0]  lo_q;
  logic [15:0] scale_q;
  logic [26:0] blk_q, blk_d, blk;

  assign pos = (tensor_start_i || pos_q >= 5'(q4d_pkg::BlockBytes)) ? 5'd0 : pos_q;
  assign blk = tensor_start_i ? 27'd0 : blk_q;
  assign weight_o = pos >= 5'd2;
  assign lane_o = 4'(pos - 5'd2);
  assign block_o = blk;
  assign scale_o = scale_q;

  always_comb begin
    pos_d = pos + 5'd1;
    blk_d = blk;
    if (pos_d == 5'(q4d_pkg::BlockBytes)) begin
      pos_d = 5'd0;
      blk_d = blk + 27'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      lo_q <= '0;
      scale_q <= '0;
      blk_q <= '0;
    end else if (take_i) begin
      pos_q <= pos_d;
      blk_q <= blk_d;
      if (pos == 5'd0) lo_q <= data_byte_i;
      if (pos == 5'd1) scale_q <= {data_byte_i, lo_q};
    end
  end
endmodule

// ===== rtl/q4d_emitter.sv =====
// Result stage: holds a weight byte and emits up to two results.
module q4d_emitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [7:0]        data_byte_i,
  input  logic [3:0]        lane_i,
  input  logic [26:0]       block_i,
  input  logic [15:0]       scale_i,
  input  logic [31:0]       count_i,
  output logic              busy_o,
  output logic              free_o,
  output logic              valid_o,
  output q4d_pkg::res_t     res_o,
  input  logic              ready_i
);
  logic        lo_v_q, hi_v_q;
  logic [31:0] lo_idx_q, hi_idx_q, lo_val_q, hi_val_q;
  logic [31:0] base, lo_idx, hi_idx;
  logic        pop;

  assign base = {block_i, 5'd0};
  assign lo_idx = base + {28'd0, lane_i};
  assign hi_idx = lo_idx + 32'd16;
  assign valid_o = lo_v_q || hi_v_q;
  assign pop = valid_o && ready_i;
  // can take a new byte when none is pending or the pending one finishes this cycle
  assign free_o = !valid_o || (pop && !(lo_v_q && hi_v_q));
  assign busy_o = valid_o;
  assign res_o.index = lo_v_q ? lo_idx_q : hi_idx_q;
  assign res_o.value = lo_v_q ? lo_val_q : hi_val_q;
  assign res_o.last = !(lo_v_q && hi_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_v_q <= 1'b0;
      hi_v_q <= 1'b0;
    end else if (load_i) begin
      lo_v_q <= lo_idx < count_i;
      hi_v_q <= hi_idx < count_i;
    end else if (pop) begin
      if (lo_v_q) lo_v_q <= 1'b0;
      else hi_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lo_idx_q <= lo_idx;
      hi_idx_q <= hi_idx;
      lo_val_q <= q4d_pkg::scaled_bits(data_byte_i[3:0], scale_i);
      hi_val_q <= q4d_pkg::scaled_bits(data_byte_i[7:4], scale_i);
    end
  end
endmodule

// ===== rtl/q4_0_block_dequantizer.sv =====
// Top level of the Q4_0 block dequantizer.
// Input stream s_axis: tdata = data_byte, tuser = tensor_start; one byte per item.
// Blocks are 18 bytes: two scale bytes (little-endian half) then 16 weight bytes.
// Each weight byte yields up to two results on m_axis: low nibble element first,
// then high nibble element (index + 16). Elements at or above element_count drop.
// m_axis tdata = {value_bits, element_index}, tlast = last result of the byte.
// The first result of a byte is valid in the cycle after the byte is accepted.
// The single result port paces the input: the next byte is taken at the earliest
// with the last result of a weight byte; scale and fully suppressed bytes hold nothing.
// cfg_* writes element_count; write only while idle. Reset value 0.
// Reset clears position, block count and scale. A stalled receiver holds
// the result register and s_axis_tready drops until it drains.
module q4_0_block_dequantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tuser,   // tensor_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // element_index[31:0], value_bits[63:32]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  logic [31:0] count_q;
  logic        take, weight, busy, free;
  logic [3:0]  lane;
  logic [26:0] blk;
  logic [15:0] scale;
  q4d_pkg::res_t res;

  assign s_axis_tready = free;
  assign take = s_axis_tvalid && free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else if (cfg_valid_i) count_q <= cfg_data_i;
  end

  q4d_parser u_parser (
    .clk_i, .rst_ni, .take_i(take), .data_byte_i(s_axis_tdata),
    .tensor_start_i(s_axis_tuser), .weight_o(weight), .lane_o(lane),
    .block_o(blk), .scale_o(scale)
  );

  q4d_emitter u_emit (
    .clk_i, .rst_ni, .load_i(take && weight), .data_byte_i(s_axis_tdata),
    .lane_i(lane), .block_i(blk), .scale_i(scale), .count_i(count_q),
    .busy_o(busy), .free_o(free), .valid_o(m_axis_tvalid), .res_o(res),
    .ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {res.value, res.index};
  assign m_axis_tlast = res.last & busy;
endmodule

// ===== rtl/q4d_checker.sv =====
// Port-level checker for the dequantizer, bound to the top level.
`include "assert_macros.svh"
module q4d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        m_axis_tlast,
  input logic [63:0] m_axis_tdata
);
  `CHK_IMPLY(a_stall_block, clk_i, rst_ni,
             m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `CHK_NEXT(a_valid_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `CHK_IMPLY(a_ready_block, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)
endmodule

bind q4_0_block_dequantizer q4d_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tlast, .m_axis_tdata
);

// ===== tb/q4_0_block_dequantizer_tb.sv =====
// Testbench for the Q4_0 block dequantizer: random and directed streams checked against a predictor.
module q4_0_block_dequantizer_tb;

  typedef struct {
    logic [31:0] index;
    logic [31:0] value;
    logic        last;
  } elem_t;

  class dequant_scoreboard;
    logic [31:0] elem_count;
    logic [4:0]  byte_pos;
    logic [7:0]  scale_lo;
    logic [15:0] scale_half;
    logic [26:0] block_num;
    elem_t       pending[$];
    int          errors;

    function new();
      elem_count = 0; byte_pos = 0; scale_lo = 0; scale_half = 0; block_num = 0;
      errors = 0;
    endfunction

    function logic [31:0] weight_bits(logic [3:0] nib, logic [15:0] h);
      logic        neg;
      logic [3:0]  mag;
      logic [31:0] sgn;
      logic [10:0] m;
      int          ex;
      logic [31:0] p;
      int          k;
      logic [31:0] bexp;
      neg = nib < 8;
      mag = neg ? 4'(8 - nib) : 4'(nib - 8);
      sgn = {neg ^ h[15], 31'd0};
      if (h[14:10] == 5'h1F) return (mag == 0) ? 32'h7FC00000 : (sgn | 32'h7F800000);
      if (h[14:10] == 0) begin
        m = {1'b0, h[9:0]}; ex = -24;
      end else begin
        m = {1'b1, h[9:0]}; ex = int'(h[14:10]) - 25;
      end
      p = mag * m;
      if (p == 0) return sgn;
      k = 13;
      while (k > 0 && p[k] == 0) k--;
      bexp = 32'(k + ex + 127);
      return sgn | (bexp << 23) | ((p << (23 - k)) & 32'h7FFFFF);
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      logic [4:0]  pos;
      logic [31:0] base;
      int          n;
      elem_t       e;
      if (start) begin
        byte_pos = 0; block_num = 0;
      end
      pos = (byte_pos >= 18) ? 5'd0 : byte_pos;
      n = 0;
      if (pos == 0) scale_lo = b;
      else if (pos == 1) scale_half = {b, scale_lo};
      else begin
        base = {block_num, 5'd0};
        if (base + pos - 2 < elem_count) begin
          e.index = base + pos - 2; e.value = weight_bits(b[3:0], scale_half); e.last = 0;
          pending = {pending, e}; n++;
        end
        if (base + pos + 14 < elem_count) begin
          e.index = base + pos + 14; e.value = weight_bits(b[7:4], scale_half); e.last = 0;
          pending = {pending, e}; n++;
        end
        if (n > 0) pending[$].last = 1;
      end
      pos++;
      if (pos >= 18) begin
        pos = 0; block_num++;
      end
      byte_pos = pos;
    endfunction

    function void check_elem(logic [31:0] idx, logic [31:0] val, logic last);
      elem_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result idx=%h val=%h", $time, idx, val);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.index !== idx) begin
        $display("%0t: index exp %h got %h", $time, e.index, idx); errors++;
      end
      if (e.value !== val) begin
        $display("%0t: value exp %h got %h", $time, e.value, val); errors++;
      end
      if (e.last !== last) begin
        $display("%0t: last exp %b got %b", $time, e.last, last); errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid_i, cfg_ready_o;
  logic [31:0] cfg_data_i;

  dequant_scoreboard sb;
  int  stall_hold;
  int  idle_cycles;
  int  sink_wait;
  int  sink_draw;
  bit  fast_sink;
  bit  stall_req;
  bit  stall_armed;

  q4_0_block_dequantizer u_dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic write_count(logic [31:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1; cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.elem_count = v;
    cfg_valid_i <= 0;
  endtask

  // valid stays up between back-to-back items; it drops only for a gap or a drain
  task automatic send_byte(logic [7:0] b, logic start, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= b; s_axis_tuser <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, start);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_block(logic start, logic [15:0] scale, bit rnd_gap);
    send_byte(scale[7:0], start, rnd_gap ? $urandom_range(0, 16) : 0);
    send_byte(scale[15:8], 0, rnd_gap ? $urandom_range(0, 16) : 0);
    for (int j = 0; j < 16; j++)
      send_byte(8'($urandom), 0, rnd_gap ? $urandom_range(0, 16) : 0);
  endtask

  function automatic logic [15:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return {1'($urandom), 5'h1F, 10'($urandom)};
      1: return {1'($urandom), 5'h00, 10'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  // sink: a drawn wait per item, or one long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 0;
      stall_hold <= 0;
      stall_armed <= 0;
      sink_wait <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_elem(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast);
      if (stall_req && !stall_armed) begin
        stall_armed <= 1;
        stall_hold <= 300;
        m_axis_tready <= 0;
      end else if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        m_axis_tready <= 0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        sink_draw = fast_sink ? 0 : $urandom_range(0, 16);
        sink_wait <= sink_draw;
        m_axis_tready <= (sink_draw == 0);
      end else if (sink_wait > 0) begin
        sink_wait <= sink_wait - 1;
        m_axis_tready <= (sink_wait == 1);
      end else m_axis_tready <= 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("q4_0_block_dequantizer_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] b;
    sb = new();
    fast_sink = 0;
    stall_req = 0;
    rst_ni = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    cfg_valid_i = 0; cfg_data_i = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;

    // count 0: everything suppressed
    send_block(1, 16'h3C00, 0);
    drain();
    write_count(32'hFFFFFFFF);
    // directed: every nibble on scale 1.0, then bytes on a NaN and a negative subnormal scale
    fast_sink = 1;
    send_byte(8'h00, 1, 0); send_byte(8'h3C, 0, 0);
    for (int j = 0; j < 16; j++) send_byte({4'(15 - j), 4'(j)}, 0, 0);
    send_byte(8'hFF, 0, 0); send_byte(8'hFC, 0, 0);   // NaN scale: sign set, all-ones exponent, non-zero mantissa
    send_byte(8'h08, 0, 0); send_byte(8'h80, 0, 0); send_byte(8'hFF, 0, 0);
    send_byte(8'h01, 1, 0); send_byte(8'h80, 0, 0);   // negative subnormal
    send_byte(8'h7F, 0, 0); send_byte(8'hF8, 0, 0); send_byte(8'h08, 0, 0);
    fast_sink = 0;
    drain();
    // partial last block
    write_count(32'd37);
    send_block(1, rand_scale(), 1);
    send_block(0, rand_scale(), 1);
    drain();
    write_count(32'd0);
    send_block(1, rand_scale(), 1);
    drain();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_count(32'hFFFFFFFF);
        1: write_count($urandom_range(1, 200));
        2: write_count(32'h80000000 | $urandom);
        default: write_count($urandom_range(1, 64));
      endcase
      if (ph == 1) stall_req = 1;
      for (int blk = 0; blk < 4; blk++) begin
        if ($urandom_range(0, 5) == 0) begin
          // noise: random-length fragment, maybe a restart mid block
          for (int j = $urandom_range(1, 20); j > 0; j--) begin
            b = 8'($urandom);
            send_byte(b, $urandom_range(0, 7) == 0, $urandom_range(0, 16));
          end
        end else
          send_block(blk == 0 || $urandom_range(0, 7) == 0, rand_scale(),
                     $urandom_range(0, 2) != 0);
      end
      drain();
    end

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("q4_0_block_dequantizer_tb: done, clean");
    else
      $display("q4_0_block_dequantizer_tb: done, errors");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/q4d_pkg.sv
rtl/q4d_parser.sv
rtl/q4d_emitter.sv
rtl/q4_0_block_dequantizer.sv
rtl/q4d_checker.sv
tb/q4_0_block_dequantizer_tb.sv
